// ===== src/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssp_pkg
// shared widths and reset values for the shortest path core
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

  localparam int DefaultNodes = 16;

  localparam int NodeW   = 4;
  localparam int WeightW = 8;
  localparam int DistW   = 16;

  localparam logic [DistW-1:0] CapReset = 16'd100;

  localparam logic KindEdge = 1'b0;
  localparam logic KindRun  = 1'b1;

endpackage

`default_nettype wire

// ===== src/single_source_shortest_paths_core.sv =====
// ----------------------------------------------------------------------------
// single_source_shortest_paths_core
// adjacency matrix store with an iterative bellman-ford relaxation sequencer
// ----------------------------------------------------------------------------
// An edge write (kind 0) is taken while idle and gives no result, so edge
// writes may follow one per cycle. A run request (kind 1) keeps busy high
// while one shared add-and-compare unit walks the matrix: it presets the
// distance of every node, then sets the source to zero, then per sweep reads
// and checks each row, reads and evaluates every edge slot of each reachable
// row and closes the sweep, at most NODES sweeps, stopping after the first
// sweep that improves nothing. The single read port of each memory sets
// this order. Results follow in node order, node 0 first, the final one
// flagged by last_o; each is shown for exactly one cycle and cannot be held
// off. After reset all 2**(2*clog2(NODES)) weight memory entries are
// cleared with busy high; configuration writes are taken during that pass
// and whenever idle.
// ----------------------------------------------------------------------------
`default_nettype none

module single_source_shortest_paths_core #(
  parameter int NODES = ssp_pkg::DefaultNodes
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             start,
  output logic                            busy,
  input  wire                             kind_i,
  input  wire  [ssp_pkg::NodeW-1:0]       from_node_i,
  input  wire  [ssp_pkg::NodeW-1:0]       to_node_i,
  input  wire  [ssp_pkg::WeightW-1:0]     weight_i,
  input  wire  [ssp_pkg::NodeW-1:0]       source_node_i,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [ssp_pkg::DistW-1:0]       cfg_data_i,
  output logic                            result_valid_o,
  output logic [ssp_pkg::NodeW-1:0]       node_o,
  output logic [ssp_pkg::DistW-1:0]       distance_o,
  output logic                            last_o
);

  import ssp_pkg::*;

  localparam int IW = $clog2(NODES);
  localparam int AW = 2 * IW;
  localparam int WDepth = 1 << AW;
  localparam logic [IW-1:0] LastIdx = IW'(NODES - 1);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_INIT     = 4'd2;
  localparam logic [3:0] S_SRC      = 4'd3;
  localparam logic [3:0] S_ROW_RD   = 4'd4;
  localparam logic [3:0] S_ROW_CHK  = 4'd5;
  localparam logic [3:0] S_EDGE_RD  = 4'd6;
  localparam logic [3:0] S_EDGE_EV  = 4'd7;
  localparam logic [3:0] S_SWEEP    = 4'd8;
  localparam logic [3:0] S_OUT_RD   = 4'd9;
  localparam logic [3:0] S_OUT_EM   = 4'd10;

  logic [3:0]         state_q, state_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic [IW-1:0]      u_q, u_d;
  logic [IW-1:0]      v_q, v_d;
  logic [IW-1:0]      sweep_q, sweep_d;
  logic [IW-1:0]      src_q, src_d;
  logic               src_ok_q, src_ok_d;
  logic               changed_q, changed_d;
  logic [DistW-1:0]   du_q, du_d;
  logic [DistW-1:0]   cap_q;

  logic               out_valid_q, out_valid_d;
  logic [NodeW-1:0]   out_node_q, out_node_d;
  logic [DistW-1:0]   out_dist_q, out_dist_d;
  logic               out_last_q, out_last_d;

  // weight memory
  logic [WeightW-1:0] wmem [WDepth];
  logic [WeightW-1:0] w_rdata_q;
  logic               w_we, w_re;
  logic [AW-1:0]      w_waddr, w_raddr;
  logic [WeightW-1:0] w_wdata;

  // distance memory
  logic [DistW-1:0]   dmem [NODES];
  logic [DistW-1:0]   d_rdata_q;
  logic               d_we, d_re;
  logic [IW-1:0]      d_waddr, d_raddr;
  logic [DistW-1:0]   d_wdata;

  logic               accept;
  logic               edge_ok;
  logic [DistW:0]     sum;
  logic [DistW-1:0]   cand;

  assign accept  = start && !busy;
  assign edge_ok = (32'(from_node_i) < NODES) && (32'(to_node_i) < NODES);

  assign sum  = {1'b0, du_q} + {{(DistW + 1 - WeightW){1'b0}}, w_rdata_q};
  assign cand = (sum >= {1'b0, cap_q}) ? cap_q : sum[DistW-1:0];

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wdata;
    end
    if (w_re) begin
      w_rdata_q <= wmem[w_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_we) begin
      dmem[d_waddr] <= d_wdata;
    end
    if (d_re) begin
      d_rdata_q <= dmem[d_raddr];
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    u_d         = u_q;
    v_d         = v_q;
    sweep_d     = sweep_q;
    src_d       = src_q;
    src_ok_d    = src_ok_q;
    changed_d   = changed_q;
    du_d        = du_q;
    out_valid_d = 1'b0;
    out_node_d  = out_node_q;
    out_dist_d  = out_dist_q;
    out_last_d  = out_last_q;
    w_we        = 1'b0;
    w_waddr     = {IW'(from_node_i), IW'(to_node_i)};
    w_wdata     = weight_i;
    w_re        = 1'b0;
    w_raddr     = {u_q, v_q};
    d_we        = 1'b0;
    d_waddr     = u_q;
    d_wdata     = cap_q;
    d_re        = 1'b0;
    d_raddr     = u_q;

    case (state_q)
      S_CLEAR: begin
        w_we    = 1'b1;
        w_waddr = clr_q;
        w_wdata = '0;
        clr_d   = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (kind_i == KindEdge) begin
            w_we = edge_ok;
          end else begin
            src_d    = IW'(source_node_i);
            src_ok_d = 32'(source_node_i) < NODES;
            u_d      = '0;
            state_d  = S_INIT;
          end
        end
      end
      S_INIT: begin
        d_we    = 1'b1;
        d_waddr = u_q;
        d_wdata = cap_q;
        u_d     = u_q + 1'b1;
        if (u_q == LastIdx) begin
          u_d     = '0;
          state_d = src_ok_q ? S_SRC : S_OUT_RD;
        end
      end
      S_SRC: begin
        d_we      = 1'b1;
        d_waddr   = src_q;
        d_wdata   = '0;
        u_d       = '0;
        sweep_d   = '0;
        changed_d = 1'b0;
        state_d   = S_ROW_RD;
      end
      S_ROW_RD: begin
        d_re    = 1'b1;
        d_raddr = u_q;
        state_d = S_ROW_CHK;
      end
      S_ROW_CHK: begin
        du_d = d_rdata_q;
        v_d  = '0;
        if (d_rdata_q < cap_q) begin
          state_d = S_EDGE_RD;
        end else if (u_q == LastIdx) begin
          state_d = S_SWEEP;
        end else begin
          u_d     = u_q + 1'b1;
          state_d = S_ROW_RD;
        end
      end
      S_EDGE_RD: begin
        w_re    = 1'b1;
        w_raddr = {u_q, v_q};
        d_re    = 1'b1;
        d_raddr = v_q;
        state_d = S_EDGE_EV;
      end
      S_EDGE_EV: begin
        if ((w_rdata_q != '0) && (cand < d_rdata_q)) begin
          d_we      = 1'b1;
          d_waddr   = v_q;
          d_wdata   = cand;
          changed_d = 1'b1;
        end
        if (v_q != LastIdx) begin
          v_d     = v_q + 1'b1;
          state_d = S_EDGE_RD;
        end else if (u_q == LastIdx) begin
          state_d = S_SWEEP;
        end else begin
          u_d     = u_q + 1'b1;
          state_d = S_ROW_RD;
        end
      end
      S_SWEEP: begin
        u_d = '0;
        if (!changed_q || sweep_q == LastIdx) begin
          state_d = S_OUT_RD;
        end else begin
          sweep_d   = sweep_q + 1'b1;
          changed_d = 1'b0;
          state_d   = S_ROW_RD;
        end
      end
      S_OUT_RD: begin
        d_re    = 1'b1;
        d_raddr = u_q;
        state_d = S_OUT_EM;
      end
      S_OUT_EM: begin
        out_valid_d = 1'b1;
        out_node_d  = NodeW'(u_q);
        out_dist_d  = (d_rdata_q > cap_q) ? cap_q : d_rdata_q;
        out_last_d  = (u_q == LastIdx);
        if (u_q == LastIdx) begin
          state_d = S_IDLE;
        end else begin
          u_d     = u_q + 1'b1;
          state_d = S_OUT_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      u_q         <= '0;
      v_q         <= '0;
      sweep_q     <= '0;
      changed_q   <= 1'b0;
      cap_q       <= CapReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      u_q         <= u_d;
      v_q         <= v_d;
      sweep_q     <= sweep_d;
      changed_q   <= changed_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    src_ok_q   <= src_ok_d;
    du_q       <= du_d;
    out_node_q <= out_node_d;
    out_dist_q <= out_dist_d;
    out_last_q <= out_last_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign cfg_ready_o    = (state_q == S_IDLE) || (state_q == S_CLEAR);
  assign result_valid_o = out_valid_q;
  assign node_o         = out_node_q;
  assign distance_o     = out_dist_q;
  assign last_o         = out_last_q;

  // a result that is not the last is followed by the next one of the run
  a_result_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> ##1 result_valid_o)
    else $error("result sequence broken");

  // reported distance never exceeds the cap
  a_dist_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> distance_o <= cap_q)
    else $error("distance above cap");

  // a run request makes the block busy
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (kind_i == KindRun) |=> busy)
    else $error("run request not started");

  // no result while idle without a pending final one
  a_no_stray_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !busy |-> last_o)
    else $error("stray result");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for single_source_shortest_paths_core
// ----------------------------------------------------------------------------
// Edge writes and run requests are queued up front, then sent by a clocked
// driver with random gaps and bursts without gaps. A monitor mirrors the
// adjacency matrix and the distance cap. For every accepted run it works out
// the sixteen expected node distances by repeated relaxation sweeps, and it
// checks each strobed result against the oldest one still waiting. The cap
// register is rewritten between phases, only once the core has gone quiet.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  import ssp_pkg::*;

  localparam int Nodes        = DefaultNodes;
  localparam int ItemTarget   = 470;
  localparam int SettleCycles = 8;
  localparam int DrainCycles  = 64;
  localparam int Limit        = 4000000;

  typedef struct {
    logic               is_cfg;
    logic [DistW-1:0]   cfg_value;
    logic               kind;
    logic [NodeW-1:0]   from_node;
    logic [NodeW-1:0]   to_node;
    logic [WeightW-1:0] weight;
    logic [NodeW-1:0]   source_node;
  } request_t;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [DistW-1:0] distance;
    logic             last;
  } path_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               start         = 1'b0;
  logic               busy;
  logic               kind_i        = KindEdge;
  logic [NodeW-1:0]   from_node_i   = '0;
  logic [NodeW-1:0]   to_node_i     = '0;
  logic [WeightW-1:0] weight_i      = '0;
  logic [NodeW-1:0]   source_node_i = '0;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [DistW-1:0]   cfg_data_i    = '0;
  logic               result_valid_o;
  logic [NodeW-1:0]   node_o;
  logic [DistW-1:0]   distance_o;
  logic               last_o;

  request_t     pending_requests [$];
  path_result_t expected_paths [$];

  logic [Nodes*Nodes-1:0][WeightW-1:0] weight_model = '0;
  logic [DistW-1:0] cap_model   = CapReset;
  logic             store_empty = 1'b1;

  int item_total      = 0;
  int mismatches      = 0;
  int results_checked = 0;
  int runs_seen       = 0;
  int edges_seen      = 0;
  int cfg_writes      = 0;
  int cycle_count     = 0;
  int gap_left        = 0;
  int settle_left     = SettleCycles;
  bit burst           = 1'b0;

  single_source_shortest_paths_core #(
    .NODES(Nodes)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .from_node_i   (from_node_i),
    .to_node_i     (to_node_i),
    .weight_i      (weight_i),
    .source_node_i (source_node_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .node_o        (node_o),
    .distance_o    (distance_o),
    .last_o        (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void push_edge(input int from_n, input int to_n, input int w);
    request_t r;
    r.is_cfg      = 1'b0;
    r.cfg_value   = DistW'($urandom);
    r.kind        = KindEdge;
    r.from_node   = NodeW'(from_n);
    r.to_node     = NodeW'(to_n);
    r.weight      = WeightW'(w);
    r.source_node = NodeW'($urandom);
    pending_requests.push_back(r);
    item_total++;
  endfunction

  function automatic void push_run(input int src);
    request_t r;
    r.is_cfg      = 1'b0;
    r.cfg_value   = DistW'($urandom);
    r.kind        = KindRun;
    r.from_node   = NodeW'($urandom);
    r.to_node     = NodeW'($urandom);
    r.weight      = WeightW'($urandom);
    r.source_node = NodeW'(src);
    pending_requests.push_back(r);
    item_total++;
  endfunction

  function automatic void push_cfg(input int value);
    request_t r;
    r.is_cfg      = 1'b1;
    r.cfg_value   = DistW'(value);
    r.kind        = KindEdge;
    r.from_node   = '0;
    r.to_node     = '0;
    r.weight      = '0;
    r.source_node = '0;
    pending_requests.push_back(r);
  endfunction

  function automatic int pick_weight();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) return 0;
    if (roll < 6) return $urandom_range(1, 15);
    return $urandom_range(0, 255);
  endfunction

  function automatic int pick_cap();
    case ($urandom_range(0, 3))
      0: return $urandom_range(1, 300);
      1: return $urandom_range(1, 65535);
      2: return 65535;
      default: return $urandom_range(200, 1200);
    endcase
  endfunction

  function automatic int next_gap();
    if ($urandom_range(0, 19) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  // bellman-ford sweeps until nothing improves, capped distances
  function automatic void predict_distances(input logic [NodeW-1:0] src);
    logic [DistW-1:0] node_dist [Nodes];
    logic [DistW:0]   sum;
    logic [DistW-1:0] cand;
    logic [WeightW-1:0] w;
    logic             improved;
    path_result_t     res;
    int               sweep;
    for (int i = 0; i < Nodes; i++) node_dist[i] = cap_model;
    node_dist[src] = '0;
    improved  = 1'b1;
    for (sweep = 0; sweep < Nodes && improved; sweep++) begin
      improved = 1'b0;
      for (int u = 0; u < Nodes; u++) begin
        if (node_dist[u] < cap_model) begin
          for (int v = 0; v < Nodes; v++) begin
            w = weight_model[u*Nodes+v];
            if (w != '0) begin
              sum  = {1'b0, node_dist[u]} + {{(DistW + 1 - WeightW){1'b0}}, w};
              cand = (sum >= {1'b0, cap_model}) ? cap_model : sum[DistW-1:0];
              if (cand < node_dist[v]) begin
                node_dist[v] = cand;
                improved     = 1'b1;
              end
            end
          end
        end
      end
    end
    for (int i = 0; i < Nodes; i++) begin
      res.node     = NodeW'(i);
      res.distance = (node_dist[i] > cap_model) ? cap_model : node_dist[i];
      res.last     = (i == Nodes - 1);
      expected_paths.push_back(res);
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    logic     start_n;
    logic     cfg_n;
    request_t head;
    if (!rst_ni) begin
      start       <= 1'b0;
      cfg_valid_i <= 1'b0;
      gap_left    = 0;
      settle_left = SettleCycles;
    end else begin
      start_n = start;
      cfg_n   = cfg_valid_i;
      if (start && !busy) begin
        start_n     = 1'b0;
        pending_requests.delete(0);
        gap_left    = next_gap();
        settle_left = SettleCycles;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_n       = 1'b0;
        pending_requests.delete(0);
        gap_left    = next_gap();
        settle_left = SettleCycles;
      end
      if (!start_n && !cfg_n && pending_requests.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          head = pending_requests[0];
          if (head.is_cfg) begin
            if (store_empty && !busy) begin
              if (settle_left > 0) begin
                settle_left--;
              end else begin
                cfg_n = 1'b1;
                cfg_data_i <= head.cfg_value;
              end
            end else begin
              settle_left = SettleCycles;
            end
          end else begin
            start_n = 1'b1;
            kind_i        <= head.kind;
            from_node_i   <= head.from_node;
            to_node_i     <= head.to_node;
            weight_i      <= head.weight;
            source_node_i <= head.source_node;
          end
        end
      end
      start       <= start_n;
      cfg_valid_i <= cfg_n;
    end
  end

  // monitor: mirrors the core state and checks every result
  always @(posedge clk_i) begin
    path_result_t got;
    path_result_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        got.node     = node_o;
        got.distance = distance_o;
        got.last     = last_o;
        if (expected_paths.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, node %0d distance %0d last %0b",
                   $time, got.node, got.distance, got.last);
        end else begin
          want = expected_paths[0];
          expected_paths.delete(0);
          results_checked++;
          if (got.node !== want.node) begin
            mismatches++;
            $display("%0t: node expected %0d got %0d", $time, want.node, got.node);
          end
          if (got.distance !== want.distance) begin
            mismatches++;
            $display("%0t: distance of node %0d expected %0d got %0d",
                     $time, want.node, want.distance, got.distance);
          end
          if (got.last !== want.last) begin
            mismatches++;
            $display("%0t: last of node %0d expected %0b got %0b",
                     $time, want.node, want.last, got.last);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cap_model = cfg_data_i;
        cfg_writes++;
      end
      if (start && !busy) begin
        if (kind_i == KindEdge) begin
          weight_model[from_node_i*Nodes+to_node_i] = weight_i;
          edges_seen++;
        end else begin
          predict_distances(source_node_i);
          runs_seen++;
        end
      end
    end
    store_empty <= (expected_paths.size() == 0);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= Limit) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, expected_paths.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int roll;
    int next_cfg_at;

    // directed: empty graph, weight extremes, saturation, removal, cap extremes
    push_run(0);
    push_edge(0, 1, 255);
    push_edge(1, 2, 1);
    push_edge(0, 2, 60);
    push_edge(2, 15, 30);
    push_edge(15, 0, 7);
    push_edge(3, 3, 9);
    push_edge(15, 14, 255);
    push_run(0);
    push_run(15);
    push_edge(0, 2, 0);
    push_run(0);
    push_cfg(65535);
    push_run(0);
    push_run(3);
    push_cfg(0);
    push_run(0);
    push_cfg(1);
    push_run(15);

    // reverse chain, one node settles per sweep
    push_cfg(65535);
    for (int i = 0; i < Nodes - 1; i++) push_edge(i + 1, i, $urandom_range(1, 255));
    push_run(Nodes - 1);

    next_cfg_at = item_total;
    while (item_total < ItemTarget) begin
      if (item_total >= next_cfg_at) begin
        push_cfg(pick_cap());
        next_cfg_at = item_total + $urandom_range(60, 110);
      end
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        repeat ($urandom_range(1, 8))
          push_edge($urandom_range(0, 15), $urandom_range(0, 15), pick_weight());
        push_run($urandom_range(0, 15));
      end else if (roll < 88) begin
        repeat ($urandom_range(1, 6)) push_edge($urandom_range(0, 15), $urandom_range(0, 15), 0);
        push_run($urandom_range(0, 15));
      end else if (roll < 94) begin
        push_run($urandom_range(0, 15));
        push_run($urandom_range(0, 15));
      end else begin
        push_edge($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 255));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || expected_paths.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("covered %0d edge writes, %0d runs and %0d cap writes",
             edges_seen, runs_seen, cfg_writes);
    $display("checked %0d node results in %0d cycles", results_checked, cycle_count);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
